/* sv/sfh_pkg.sv */
package sfh_pkg;

  localparam int MAX_QUEUES_DEF = 16;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam int KEY_BYTES          = 12;
  localparam int HASH_W             = 32;
  localparam int MIX_STAGES         = KEY_BYTES;
  localparam int MOD_BITS_PER_STAGE = 8;
  localparam int MOD_STAGES         = HASH_W / MOD_BITS_PER_STAGE;
  localparam int PIPE_DEPTH         = 1 + MIX_STAGES + 1 + MOD_STAGES;

  localparam int QIDX_W = 4;

  localparam int              SPLIT_W     = 5;
  localparam logic [SPLIT_W-1:0] SPLIT_RESET = 5'd2;
  localparam int              CFG_ADDR_W  = 3;
  localparam int              CFG_DATA_W  = 32;
  localparam logic            REG_SPLIT_COUNT = 1'b0;

  typedef logic [HASH_W-1:0]      hash_t;
  typedef logic [KEY_BYTES*8-1:0] key_t;

  typedef struct packed {
    logic valid;
    logic hashed;
  } ctl_t;

  // One byte step of the one-at-a-time hash; the byte is taken as a signed char.
  function automatic hash_t oaat_add(hash_t h, logic [7:0] b);
    hash_t x;
    x = h + {{(HASH_W-8){b[7]}}, b};
    x = x + (x << 10);
    x = x ^ (x >> 6);
    return x;
  endfunction

endpackage

/* sv/sfh_key.sv */
module sfh_key (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic [15:0]          ether_type_i,
  input  logic [3:0]           ip_version_i,
  input  logic [7:0]           ip_protocol_i,
  input  logic [31:0]          src_addr_i,
  input  logic [31:0]          dst_addr_i,
  input  logic [15:0]          src_port_i,
  input  logic [15:0]          dst_port_i,
  output sfh_pkg::ctl_t        ctl_o,
  output sfh_pkg::key_t        key_o
);

  sfh_pkg::ctl_t ctl_r, ctl_nxt;
  sfh_pkg::key_t key_r, key_nxt;

  logic [31:0] src_swap, dst_swap;
  logic        src_first;
  logic        ports_used;
  logic [31:0] first_a, second_a;
  logic [15:0] first_p, second_p;

  // Addresses are ordered as a little-endian load would see them.
  assign src_swap = {src_addr_i[7:0], src_addr_i[15:8], src_addr_i[23:16], src_addr_i[31:24]};
  assign dst_swap = {dst_addr_i[7:0], dst_addr_i[15:8], dst_addr_i[23:16], dst_addr_i[31:24]};
  assign src_first  = src_swap > dst_swap;
  assign ports_used = (ip_protocol_i == sfh_pkg::PROTO_TCP) ||
                      (ip_protocol_i == sfh_pkg::PROTO_UDP);

  always_comb begin
    first_a  = src_first ? src_addr_i : dst_addr_i;
    second_a = src_first ? dst_addr_i : src_addr_i;
    first_p  = '0;
    second_p = '0;
    if (ports_used) begin
      first_p  = src_first ? src_port_i : dst_port_i;
      second_p = src_first ? dst_port_i : src_port_i;
    end
    key_nxt        = {first_a, second_a, first_p, second_p};
    ctl_nxt.valid  = valid_i;
    ctl_nxt.hashed = (ether_type_i == sfh_pkg::ETHERTYPE_IPV4) &&
                     (ip_version_i == sfh_pkg::IP_VERSION_4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign ctl_o = ctl_r;
  assign key_o = key_r;

endmodule

/* sv/sfh_mix.sv */
module sfh_mix (
  input  logic           clk,
  input  logic           rst_n,
  input  sfh_pkg::ctl_t  ctl_i,
  input  sfh_pkg::hash_t h_i,
  input  sfh_pkg::key_t  key_i,
  output sfh_pkg::ctl_t  ctl_o,
  output sfh_pkg::hash_t h_o,
  output sfh_pkg::key_t  key_o
);

  sfh_pkg::ctl_t  ctl_r;
  sfh_pkg::hash_t h_r, h_nxt;
  sfh_pkg::key_t  key_r, key_nxt;

  // The key shifts up one byte per stage, so each stage takes the top byte.
  assign h_nxt   = sfh_pkg::oaat_add(h_i, key_i[sfh_pkg::KEY_BYTES*8-1 -: 8]);
  assign key_nxt = key_i << 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    key_r <= key_nxt;
  end

  assign ctl_o = ctl_r;
  assign h_o   = h_r;
  assign key_o = key_r;

endmodule

/* sv/sfh_final.sv */
module sfh_final (
  input  logic           clk,
  input  logic           rst_n,
  input  sfh_pkg::ctl_t  ctl_i,
  input  sfh_pkg::hash_t h_i,
  output sfh_pkg::ctl_t  ctl_o,
  output sfh_pkg::hash_t h_o
);

  sfh_pkg::ctl_t  ctl_r;
  sfh_pkg::hash_t h_r, h_nxt;
  sfh_pkg::hash_t a, b;

  always_comb begin
    a     = h_i + (h_i << 3);
    b     = a ^ (a >> 11);
    h_nxt = b + (b << 15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
  end

  assign ctl_o = ctl_r;
  assign h_o   = h_r;

endmodule

/* sv/sfh_mod.sv */
module sfh_mod #(
  parameter int MAX_QUEUES = sfh_pkg::MAX_QUEUES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sfh_pkg::ctl_t                        ctl_i,
  input  sfh_pkg::hash_t                       h_i,
  input  logic [$clog2(MAX_QUEUES+1)-1:0]      r_i,
  input  logic [$clog2(MAX_QUEUES+1)-1:0]      n_i,
  output sfh_pkg::ctl_t                        ctl_o,
  output sfh_pkg::hash_t                       h_o,
  output logic [$clog2(MAX_QUEUES+1)-1:0]      r_o
);

  localparam int NW = $clog2(MAX_QUEUES+1);

  sfh_pkg::ctl_t  ctl_r;
  sfh_pkg::hash_t h_r, h_nxt;
  logic [NW-1:0]  r_r, r_nxt;
  logic [NW:0]    t_c;

  // Restoring remainder, one dividend bit per step, most significant first.
  always_comb begin
    h_nxt = h_i;
    r_nxt = r_i;
    t_c   = '0;
    for (int i = 0; i < sfh_pkg::MOD_BITS_PER_STAGE; i++) begin
      t_c   = {r_nxt, h_nxt[sfh_pkg::HASH_W-1]};
      h_nxt = h_nxt << 1;
      if (t_c >= {1'b0, n_i}) begin
        t_c = t_c - {1'b0, n_i};
      end
      r_nxt = t_c[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    r_r <= r_nxt;
  end

  assign ctl_o = ctl_r;
  assign h_o   = h_r;
  assign r_o   = r_r;

endmodule

/* sv/symmetric_flow_hash_dispatch.sv */
// Maps the header fields of one IPv4 packet to an output queue so that both
// directions of a flow share a queue. A request is taken on every cycle in
// which start is high; busy never rises. The queue appears on out_queue_index
// for one cycle, marked by out_valid; the receiver cannot hold it off. The
// pipeline holds one stage that builds the key, twelve stages that each mix
// one key byte, one finishing stage, and a four-stage remainder unit that
// retires eight hash bits per stage. split_count may only be written while no
// request is in flight.
module symmetric_flow_hash_dispatch #(
  parameter int MAX_QUEUES = sfh_pkg::MAX_QUEUES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [15:0]                     in_ether_type,
  input  logic [3:0]                      in_ip_version,
  input  logic [7:0]                      in_ip_protocol,
  input  logic [31:0]                     in_src_addr,
  input  logic [31:0]                     in_dst_addr,
  input  logic [15:0]                     in_src_port,
  input  logic [15:0]                     in_dst_port,
  output logic                            out_valid,
  output logic [sfh_pkg::QIDX_W-1:0]      out_queue_index,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfh_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sfh_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sfh_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int NW = $clog2(MAX_QUEUES+1);

  logic [sfh_pkg::SPLIT_W-1:0] split_count_r, split_count_nxt;
  logic [NW-1:0]               n_eff;
  logic                        accept;
  logic                        cfg_write;

  sfh_pkg::ctl_t  mix_ctl [sfh_pkg::MIX_STAGES+1];
  sfh_pkg::hash_t mix_h   [sfh_pkg::MIX_STAGES+1];
  sfh_pkg::key_t  mix_key [sfh_pkg::MIX_STAGES+1];

  sfh_pkg::ctl_t  fin_ctl;
  sfh_pkg::hash_t fin_h;

  sfh_pkg::ctl_t  mod_ctl [sfh_pkg::MOD_STAGES+1];
  sfh_pkg::hash_t mod_h   [sfh_pkg::MOD_STAGES+1];
  logic [NW-1:0]  mod_r   [sfh_pkg::MOD_STAGES+1];

  // The pipeline never stalls, so a request is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == sfh_pkg::REG_SPLIT_COUNT);

  always_comb begin
    split_count_nxt = split_count_r;
    if (cfg_write) begin
      split_count_nxt = pwdata[sfh_pkg::SPLIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_count_r <= sfh_pkg::SPLIT_RESET;
    end else begin
      split_count_r <= split_count_nxt;
    end
  end

  assign prdata = (paddr[2] == sfh_pkg::REG_SPLIT_COUNT) ?
                  sfh_pkg::CFG_DATA_W'(split_count_r) : '0;

  assign n_eff = (32'(split_count_r) > 32'(MAX_QUEUES)) ? NW'(MAX_QUEUES)
                                                         : NW'(split_count_r);

  sfh_key u_key (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (accept),
    .ether_type_i  (in_ether_type),
    .ip_version_i  (in_ip_version),
    .ip_protocol_i (in_ip_protocol),
    .src_addr_i    (in_src_addr),
    .dst_addr_i    (in_dst_addr),
    .src_port_i    (in_src_port),
    .dst_port_i    (in_dst_port),
    .ctl_o         (mix_ctl[0]),
    .key_o         (mix_key[0])
  );

  assign mix_h[0] = '0;

  for (genvar g = 0; g < sfh_pkg::MIX_STAGES; g++) begin : g_mix
    sfh_mix u_mix (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (mix_ctl[g]),
      .h_i   (mix_h[g]),
      .key_i (mix_key[g]),
      .ctl_o (mix_ctl[g+1]),
      .h_o   (mix_h[g+1]),
      .key_o (mix_key[g+1])
    );
  end

  sfh_final u_final (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (mix_ctl[sfh_pkg::MIX_STAGES]),
    .h_i   (mix_h[sfh_pkg::MIX_STAGES]),
    .ctl_o (fin_ctl),
    .h_o   (fin_h)
  );

  assign mod_ctl[0] = fin_ctl;
  assign mod_h[0]   = fin_h;
  assign mod_r[0]   = '0;

  for (genvar g = 0; g < sfh_pkg::MOD_STAGES; g++) begin : g_mod
    sfh_mod #(
      .MAX_QUEUES (MAX_QUEUES)
    ) u_mod (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (mod_ctl[g]),
      .h_i   (mod_h[g]),
      .r_i   (mod_r[g]),
      .n_i   (n_eff),
      .ctl_o (mod_ctl[g+1]),
      .h_o   (mod_h[g+1]),
      .r_o   (mod_r[g+1])
    );
  end

  // Non-IPv4 packets and a zero queue count both go to queue zero.
  assign out_valid       = mod_ctl[sfh_pkg::MOD_STAGES].valid;
  assign out_queue_index = (mod_ctl[sfh_pkg::MOD_STAGES].hashed && (n_eff != '0)) ?
                           sfh_pkg::QIDX_W'(mod_r[sfh_pkg::MOD_STAGES]) : '0;

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(sfh_pkg::PIPE_DEPTH) out_valid)
    else $error("request did not produce a result at the fixed latency");

  a_queue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (n_eff != '0) |-> 32'(out_queue_index) < 32'(n_eff))
    else $error("queue index not below the queue count");

  a_non_ipv4_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ether_type != sfh_pkg::ETHERTYPE_IPV4)
      |-> ##(sfh_pkg::PIPE_DEPTH) (out_queue_index == '0))
    else $error("non-IPv4 request not sent to queue zero");

endmodule
